/* sv/tmrv_pkg.sv */
// ============================================================================
// tmrv_pkg - shared types and constants of the mirror register voter
// Mode and repair codes, sequencer states and the vote result record.
// ============================================================================
package tmrv_pkg;

    localparam int ENTRY_COUNT_DEF = 8;
    localparam int HALF_BITS       = 16;
    localparam int WORD_BITS       = 2 * HALF_BITS;
    localparam int INDEX_BITS      = 5;
    localparam int MODE_BITS       = 3;
    localparam int REPAIR_BITS     = 2;

    localparam logic [MODE_BITS-1:0] MODE_READ       = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_WRITE      = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR      = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_INJ_PLAIN  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_INJ_MIRROR = 3'd4;

    localparam logic [REPAIR_BITS-1:0] REP_NONE   = 2'd0;
    localparam logic [REPAIR_BITS-1:0] REP_MIRROR = 2'd1;
    localparam logic [REPAIR_BITS-1:0] REP_PLAIN  = 2'd2;
    localparam logic [REPAIR_BITS-1:0] REP_BOTH   = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [HALF_BITS-1:0]   data;
        logic [REPAIR_BITS-1:0] repair;
        logic                   fix_plain;
        logic                   fix_mirror;
    } vote_t;

endpackage

/* sv/tmrv_if.sv */
// ============================================================================
// tmrv_if - request and response channels of the mirror register voter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
interface tmrv_in_if;
    import tmrv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_BITS-1:0]  mode;
    logic [INDEX_BITS-1:0] index;
    logic [HALF_BITS-1:0]  value;
    logic [WORD_BITS-1:0]  raw_word;

    modport source (output valid, mode, index, value, raw_word, input ready);
    modport sink   (input valid, mode, index, value, raw_word, output ready);
endinterface

interface tmrv_out_if;
    import tmrv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HALF_BITS-1:0]   read_data;
    logic [REPAIR_BITS-1:0] repair;
    logic                   index_valid;

    modport source (output valid, read_data, repair, index_valid, input ready);
    modport sink   (input valid, read_data, repair, index_valid, output ready);
endinterface

/* sv/triple_mirror_register_voter_core.sv */
// ============================================================================
// triple_mirror_register_voter_core - scrubbing register file, triple copies
// Plain and mirror RAMs with per-entry valid bits, vote and write-back.
// ============================================================================
// Each request beat passes through ST_IDLE and ST_EXEC: in ST_IDLE it is
// accepted and both RAMs are read at the requested entry, and in ST_EXEC,
// once the output register is free or drained, the copies are voted, repairs
// or writes go back to the RAMs and the response is loaded into the output
// register. The single read port of each RAM and its registered read data set
// this order; no new beat is accepted before that response is loaded. Clear-all
// acts through per-entry valid bits; an entry whose bit is clear reads as zero.
module triple_mirror_register_voter_core #(
    parameter int ENTRY_COUNT = tmrv_pkg::ENTRY_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    tmrv_in_if.sink           in_ch,
    tmrv_out_if.source        out_ch
);
    import tmrv_pkg::*;

    localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam logic [INDEX_BITS:0] COUNT = (INDEX_BITS + 1)'(ENTRY_COUNT);

    state_t state_reg;
    state_t state_next;

    logic [MODE_BITS-1:0]  mode_reg;
    logic [INDEX_BITS-1:0] index_reg;
    logic [HALF_BITS-1:0]  value_reg;
    logic [WORD_BITS-1:0]  raw_reg;

    logic [ENTRY_COUNT-1:0] plain_valid_reg;
    logic [ENTRY_COUNT-1:0] plain_valid_next;
    logic [ENTRY_COUNT-1:0] mirror_valid_reg;
    logic [ENTRY_COUNT-1:0] mirror_valid_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [HALF_BITS-1:0]   out_data_reg;
    logic [HALF_BITS-1:0]   out_data_next;
    logic [REPAIR_BITS-1:0] out_repair_reg;
    logic [REPAIR_BITS-1:0] out_repair_next;
    logic                   out_ok_reg;
    logic                   out_ok_next;

    logic                 accept;
    logic                 fire;
    logic                 ok;
    logic [AW-1:0]        addr;
    logic [HALF_BITS-1:0] plain_q;
    logic [WORD_BITS-1:0] mirror_q;
    logic [HALF_BITS-1:0] plain_cur;
    logic [WORD_BITS-1:0] mirror_cur;
    vote_t                vote;

    logic                 plain_we;
    logic [HALF_BITS-1:0] plain_wd;
    logic                 mirror_we;
    logic [WORD_BITS-1:0] mirror_wd;

    assign accept = in_ch.valid && in_ch.ready;
    assign fire   = (state_reg == ST_EXEC) && (!out_valid_reg || out_ch.ready);
    assign ok     = {1'b0, index_reg} < COUNT;
    assign addr   = index_reg[AW-1:0];

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_ch.mode;
            index_reg <= in_ch.index;
            value_reg <= in_ch.value;
            raw_reg   <= in_ch.raw_word;
        end
    end

    // ---------------------------------------------------------------- storage
    tmrv_ram #(
        .WIDTH (HALF_BITS),
        .DEPTH (ENTRY_COUNT)
    ) u_plain_ram (
        .clk   (clk),
        .we    (plain_we),
        .waddr (addr),
        .wdata (plain_wd),
        .re    (accept),
        .raddr (in_ch.index[AW-1:0]),
        .rdata (plain_q)
    );

    tmrv_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ENTRY_COUNT)
    ) u_mirror_ram (
        .clk   (clk),
        .we    (mirror_we),
        .waddr (addr),
        .wdata (mirror_wd),
        .re    (accept),
        .raddr (in_ch.index[AW-1:0]),
        .rdata (mirror_q)
    );

    // never-written or cleared entries read as zero
    assign plain_cur  = (ok && plain_valid_reg[addr])  ? plain_q  : '0;
    assign mirror_cur = (ok && mirror_valid_reg[addr]) ? mirror_q : '0;

    tmrv_vote u_vote (
        .plain  (plain_cur),
        .mirror (mirror_cur),
        .vote   (vote)
    );

    // ---------------------------------------------------------------- write-back
    always_comb
    begin
        plain_we  = 1'b0;
        plain_wd  = value_reg;
        mirror_we = 1'b0;
        mirror_wd = {value_reg, value_reg};
        if (fire && ok)
        begin
            case (mode_reg)
                MODE_READ:
                begin
                    plain_we  = vote.fix_plain;
                    plain_wd  = vote.data;
                    mirror_we = vote.fix_mirror;
                    mirror_wd = {vote.data, vote.data};
                end
                MODE_WRITE:
                begin
                    plain_we  = 1'b1;
                    mirror_we = 1'b1;
                end
                MODE_INJ_PLAIN:
                begin
                    plain_we = 1'b1;
                end
                MODE_INJ_MIRROR:
                begin
                    mirror_we = 1'b1;
                    mirror_wd = raw_reg;
                end
                default:
                begin
                    plain_we  = 1'b0;
                    mirror_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        plain_valid_next  = plain_valid_reg;
        mirror_valid_next = mirror_valid_reg;
        if (fire && mode_reg == MODE_CLEAR)
        begin
            plain_valid_next  = '0;
            mirror_valid_next = '0;
        end
        else
        begin
            if (plain_we)
            begin
                plain_valid_next[addr] = 1'b1;
            end
            if (mirror_we)
            begin
                mirror_valid_next[addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_valid_reg  <= '0;
            mirror_valid_reg <= '0;
        end
        else
        begin
            plain_valid_reg  <= plain_valid_next;
            mirror_valid_reg <= mirror_valid_next;
        end
    end

    // ---------------------------------------------------------------- response
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_repair_next = out_repair_reg;
        out_ok_next     = out_ok_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next  = 1'b1;
            out_ok_next     = ok;
            out_data_next   = '0;
            out_repair_next = REP_NONE;
            if (ok && mode_reg == MODE_READ)
            begin
                out_data_next   = vote.data;
                out_repair_next = vote.repair;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_repair_reg <= out_repair_next;
        out_ok_reg     <= out_ok_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.read_data   = out_data_reg;
    assign out_ch.repair      = out_repair_reg;
    assign out_ch.index_valid = out_ok_reg;

endmodule

/* sv/tmrv_ram.sv */
// ============================================================================
// tmrv_ram - generic single-write, single-read synchronous RAM
// Registered read data; the output holds while no read is issued.
// ============================================================================
module tmrv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tmrv_vote.sv */
// ============================================================================
// tmrv_vote - majority vote over the three copies of one entry
// Picks the winning value and flags which copies need a rewrite.
// ============================================================================
module tmrv_vote (
    input  logic [tmrv_pkg::HALF_BITS-1:0] plain,
    input  logic [tmrv_pkg::WORD_BITS-1:0] mirror,
    output tmrv_pkg::vote_t                vote
);
    import tmrv_pkg::*;

    logic [HALF_BITS-1:0] lo;
    logic [HALF_BITS-1:0] hi;

    assign lo = mirror[HALF_BITS-1:0];
    assign hi = mirror[WORD_BITS-1:HALF_BITS];

    always_comb
    begin
        vote.data       = plain;
        vote.repair     = REP_NONE;
        vote.fix_plain  = 1'b0;
        vote.fix_mirror = 1'b0;
        if (hi == lo && lo == plain)
        begin
            vote.repair = REP_NONE;
        end
        else if (plain == lo || plain == hi)
        begin
            vote.repair     = REP_MIRROR;
            vote.fix_mirror = 1'b1;
        end
        else if (lo == hi)
        begin
            vote.data      = lo;
            vote.repair    = REP_PLAIN;
            vote.fix_plain = 1'b1;
        end
        else
        begin
            // no two copies agree: the smaller half wins
            vote.data       = (hi > lo) ? lo : hi;
            vote.repair     = REP_BOTH;
            vote.fix_plain  = 1'b1;
            vote.fix_mirror = 1'b1;
        end
    end

endmodule

/* sim/triple_mirror_register_voter_core_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// triple_mirror_register_voter_core_test - self-checking bench of the voter
// Drives reads, writes, clear-all and fault injects through the request
// channel. It keeps its own copy of the plain and mirror stores, forecasts
// the vote and scrub of every accepted beat, and compares each response beat
// in order. Sender and receiver idle at random in the first two of three phases.
// ============================================================================
module triple_mirror_register_voter_core_test;
    import tmrv_pkg::*;

    localparam int ENTRY_COUNT   = ENTRY_COUNT_DEF;
    localparam int INDEX_MAX     = (1 << INDEX_BITS) - 1;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 16;
    localparam int PHASE_BEATS   = 210;

    localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [HALF_BITS-1:0]   read_data;
        logic [REPAIR_BITS-1:0] repair;
        logic                   index_valid;
    } vote_reply_t;

    class vote_board;
        logic [HALF_BITS-1:0] plain_shadow [ENTRY_COUNT];
        logic [WORD_BITS-1:0] mirror_shadow [ENTRY_COUNT];
        vote_reply_t          expected_votes [$];
        int                   errors;
        int                   beats_seen;
        int                   mode_hits [8];
        int                   repair_hits [4];
        int                   out_of_range;

        function new();
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                plain_shadow[i]  = '0;
                mirror_shadow[i] = '0;
            end
        endfunction

        function int pending();
            return expected_votes.size();
        endfunction

        // Applies one request to the shadow stores and returns its response.
        function vote_reply_t predict_vote(logic [MODE_BITS-1:0] mode,
                                           logic [INDEX_BITS-1:0] idx,
                                           logic [HALF_BITS-1:0] val,
                                           logic [WORD_BITS-1:0] raw);
            vote_reply_t          reply;
            logic [HALF_BITS-1:0] p;
            logic [HALF_BITS-1:0] lo;
            logic [HALF_BITS-1:0] hi;
            logic [HALF_BITS-1:0] win;
            logic                 ok;

            ok = (idx < ENTRY_COUNT);
            reply = '0;
            reply.index_valid = ok;
            reply.repair = REP_NONE;
            case (mode)
                MODE_READ:
                begin
                    if (ok)
                    begin
                        p  = plain_shadow[idx];
                        lo = mirror_shadow[idx][HALF_BITS-1:0];
                        hi = mirror_shadow[idx][WORD_BITS-1:HALF_BITS];
                        reply.read_data = p;
                        if (!(hi == lo && lo == p))
                        begin
                            if (p == lo || p == hi)
                            begin
                                mirror_shadow[idx] = {p, p};
                                reply.repair = REP_MIRROR;
                            end
                            else if (lo == hi)
                            begin
                                plain_shadow[idx] = lo;
                                reply.read_data = lo;
                                reply.repair = REP_PLAIN;
                            end
                            else
                            begin
                                win = (hi > lo) ? lo : hi;
                                mirror_shadow[idx] = {win, win};
                                plain_shadow[idx] = win;
                                reply.read_data = win;
                                reply.repair = REP_BOTH;
                            end
                        end
                        repair_hits[reply.repair]++;
                    end
                end
                MODE_WRITE:
                begin
                    if (ok)
                    begin
                        plain_shadow[idx]  = val;
                        mirror_shadow[idx] = {val, val};
                    end
                end
                MODE_CLEAR:
                    wipe();
                MODE_INJ_PLAIN:
                begin
                    if (ok)
                        plain_shadow[idx] = val;
                end
                MODE_INJ_MIRROR:
                begin
                    if (ok)
                        mirror_shadow[idx] = raw;
                end
                default: ;
            endcase
            return reply;
        endfunction

        function void note_request(logic [MODE_BITS-1:0] mode, logic [INDEX_BITS-1:0] idx,
                                   logic [HALF_BITS-1:0] val, logic [WORD_BITS-1:0] raw);
            mode_hits[mode]++;
            if (idx >= ENTRY_COUNT)
                out_of_range++;
            expected_votes.push_back(predict_vote(mode, idx, val, raw));
        endfunction

        task report_mismatch(string what, logic [WORD_BITS-1:0] got,
                             logic [WORD_BITS-1:0] want);
            $display("tb: mismatch on response %0d, %s: got %0h, want %0h",
                     beats_seen, what, got, want);
            errors++;
        endtask

        task check_reply(vote_reply_t got);
            vote_reply_t want;

            beats_seen++;
            if (expected_votes.size() == 0)
            begin
                report_mismatch("unexpected beat", WORD_BITS'(got), '0);
            end
            else
            begin
                want = expected_votes.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", WORD_BITS'(got.read_data),
                                    WORD_BITS'(want.read_data));
                if (got.repair !== want.repair)
                    report_mismatch("repair", WORD_BITS'(got.repair),
                                    WORD_BITS'(want.repair));
                if (got.index_valid !== want.index_valid)
                    report_mismatch("index_valid", WORD_BITS'(got.index_valid),
                                    WORD_BITS'(want.index_valid));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;
    int   idle_cycles;

    logic [INDEX_BITS-1:0] recent_index;
    logic [HALF_BITS-1:0]  recent_half;

    vote_board board;

    tmrv_in_if  req_ch ();
    tmrv_out_if rsp_ch ();

    triple_mirror_register_voter_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Receiver stalls at random.
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            board.check_reply({rsp_ch.read_data, rsp_ch.repair, rsp_ch.index_valid});
        if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.mode, req_ch.index, req_ch.value, req_ch.raw_word);
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb: timeout after %0d cycles without a beat", STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(input logic [MODE_BITS-1:0] mode,
                                input logic [INDEX_BITS-1:0] idx,
                                input logic [HALF_BITS-1:0] val,
                                input logic [WORD_BITS-1:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.index    <= idx;
        req_ch.value    <= val;
        req_ch.raw_word <= raw;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (board.pending() > 0)
            @(negedge clk);
    endtask

    // Small values, values near the top and repeats make the copies collide.
    function automatic logic [HALF_BITS-1:0] pick_half();
        case ($urandom_range(3))
            0: recent_half = HALF_BITS'($urandom);
            1: recent_half = HALF_BITS'($urandom_range(3));
            2: recent_half = HALF_BITS'(16'hFFFF - $urandom_range(2));
            default: ;
        endcase
        return recent_half;
    endfunction

    task automatic send_random(input int count);
        logic [MODE_BITS-1:0]  mode;
        logic [INDEX_BITS-1:0] idx;
        logic [HALF_BITS-1:0]  val;
        logic [WORD_BITS-1:0]  raw;
        logic [HALF_BITS-1:0]  half;
        int                    pick;

        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                mode = MODE_READ;
            else if (pick < 58)
                mode = MODE_WRITE;
            else if (pick < 74)
                mode = MODE_INJ_PLAIN;
            else if (pick < 95)
                mode = MODE_INJ_MIRROR;
            else if (pick < 98)
                mode = MODE_CLEAR;
            else
                mode = MODE_READ;
            // Often stay on one entry so injects are followed by votes on it.
            if ($urandom_range(9) == 0)
                idx = INDEX_BITS'($urandom_range(INDEX_MAX, ENTRY_COUNT));
            else if ($urandom_range(1) == 0)
                idx = recent_index;
            else
                idx = INDEX_BITS'($urandom_range(ENTRY_COUNT - 1));
            if (idx < ENTRY_COUNT)
                recent_index = idx;
            val = pick_half();
            case ($urandom_range(4))
                0: raw = $urandom;
                1:
                begin
                    half = pick_half();
                    raw = {half, half};
                end
                default: raw = {pick_half(), pick_half()};
            endcase
            send_request(mode, idx, val, raw);
        end
    endtask

    initial
    begin
        board = new();
        idle_cycles = 0;
        recent_index = '0;
        recent_half = '0;
        gap_pct = 13;
        stall_pct = 80;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_READ;
        req_ch.index = '0;
        req_ch.value = '0;
        req_ch.raw_word = '0;
        rsp_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every vote outcome, range edges, clear-all, spare modes
        send_request(MODE_READ, 0, 16'h0000, '0);
        send_request(MODE_WRITE, 0, 16'hFFFF, '0);
        send_request(MODE_READ, 0, 16'h0000, '0);
        send_request(MODE_WRITE, 7, 16'hA5A5, '0);
        send_request(MODE_INJ_MIRROR, 7, 16'h0000, 32'hA5A5_0000);
        send_request(MODE_READ, 7, 16'h0000, '0);
        send_request(MODE_INJ_MIRROR, 7, 16'h0000, 32'h0000_A5A5);
        send_request(MODE_READ, 7, 16'h0000, '0);
        send_request(MODE_INJ_PLAIN, 7, 16'h1234, '0);
        send_request(MODE_READ, 7, 16'h0000, '0);
        send_request(MODE_INJ_MIRROR, 3, 16'h0000, 32'h0005_FFFF);
        send_request(MODE_READ, 3, 16'h0000, '0);
        send_request(MODE_INJ_MIRROR, 3, 16'h0000, 32'hFFFF_0001);
        send_request(MODE_READ, 3, 16'h0000, '0);
        send_request(MODE_READ, 3, 16'h0000, '0);
        send_request(MODE_INJ_MIRROR, 1, 16'h0000, 32'hFFFF_FFFF);
        send_request(MODE_READ, 1, 16'h0000, '0);
        send_request(MODE_WRITE, INDEX_BITS'(INDEX_MAX), 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_INJ_PLAIN, INDEX_BITS'(ENTRY_COUNT), 16'hFFFF, '0);
        send_request(MODE_INJ_MIRROR, INDEX_BITS'(ENTRY_COUNT), 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_READ, INDEX_BITS'(ENTRY_COUNT), 16'h0000, '0);
        send_request(MODE_CLEAR, INDEX_BITS'(INDEX_MAX), 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_READ, 0, 16'h0000, '0);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_request(MODE_BITS'(m), 0, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_READ, 7, 16'h0000, '0);

        send_random(PHASE_BEATS);
        wait_drained();

        gap_pct = 80;
        stall_pct = 13;
        send_random(PHASE_BEATS);
        wait_drained();

        gap_pct = 0;
        stall_pct = 0;
        send_random(PHASE_BEATS);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $write("tb: %0d requests: %0d reads, %0d writes, %0d clears, ",
               board.beats_seen, board.mode_hits[MODE_READ], board.mode_hits[MODE_WRITE],
               board.mode_hits[MODE_CLEAR]);
        $display("%0d plain and %0d mirror injects, %0d out of range",
                 board.mode_hits[MODE_INJ_PLAIN], board.mode_hits[MODE_INJ_MIRROR],
                 board.out_of_range);
        $display("tb: votes: %0d clean, %0d mirror fixed, %0d plain fixed, %0d both rewritten",
                 board.repair_hits[REP_NONE], board.repair_hits[REP_MIRROR],
                 board.repair_hits[REP_PLAIN], board.repair_hits[REP_BOTH]);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
